@@ sv/bda_pkg.sv @@
// Shared constants and controller/datapath interface types for the decimal ASCII converter.
`default_nettype none
package bda_pkg;
	localparam int VALUE_W    = 64;
	localparam int DIG_W      = 4;
	localparam int BCD_DIGITS = 20;
	localparam int BCD_W      = BCD_DIGITS * DIG_W;
	localparam int BIT_W      = 6;
	localparam int CNT_W      = 5;
	localparam int CHAR_W     = 6;
	localparam int TDATA_W    = 8;

	localparam logic [BIT_W-1:0]  LAST_BIT   = BIT_W'(VALUE_W - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(BCD_DIGITS);
	localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef struct packed {
		logic load;
		logic step;
		logic skip;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic bits_done;
		logic top_zero;
		logic cnt_one;
		logic out_free;
	} dp_sts_t;
endpackage
`default_nettype wire

@@ sv/bda_dp.sv @@
// Datapath: double dabble shift register, digit scanner and output register.
`default_nettype none
module bda_dp
	import bda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_sts_t                 sts,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,
	output logic                    m_tlast
);
	logic [VALUE_W-1:0] val_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;
	logic [BIT_W-1:0]   bit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIG_W-1:0]   top_dig;
	logic               out_vld_q;
	logic [TDATA_W-1:0] out_data_q;
	logic               out_last_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[i*DIG_W +: DIG_W] >= DIG_W'(5))
				adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W] + DIG_W'(3);
			else
				adj[i*DIG_W +: DIG_W] = bcd_q[i*DIG_W +: DIG_W];
		end
	end

	assign top_dig       = bcd_q[BCD_W-1 -: DIG_W];
	assign sts.bits_done = (bit_q == LAST_BIT);
	assign sts.top_zero  = (top_dig == '0);
	assign sts.cnt_one   = (cnt_q == CNT_ONE);
	assign sts.out_free  = !out_vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
			bcd_q <= '0;
			bit_q <= '0;
			cnt_q <= CNT_FULL;
		end else if (cmd.step) begin
			val_q <= {val_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], val_q[VALUE_W-1]};
			bit_q <= bit_q + BIT_W'(1);
		end else if (cmd.skip || cmd.emit) begin
			bcd_q <= {bcd_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.emit) begin
			out_data_q <= {2'b00, ASCII_ZERO + {2'b00, top_dig}};
			out_last_q <= sts.cnt_one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
endmodule
`default_nettype wire

@@ sv/bda_ctrl.sv @@
// Controller: sequences load, 64 shift steps, leading-zero skip and digit output.
`default_nettype none
module bda_ctrl
	import bda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && s_tvalid;
		cmd.step = (state_q == ST_CONV);
		cmd.skip = (state_q == ST_SCAN) && sts.top_zero && !sts.cnt_one;
		cmd.emit = (state_q == ST_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CONV;
						ready_q <= 1'b0;
					end
				end
				ST_CONV: begin
					if (sts.bits_done)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!sts.top_zero || sts.cnt_one)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free && sts.cnt_one) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;
endmodule
`default_nettype wire

@@ sv/binary_to_decimal_ascii.sv @@
// Top level: 64-bit unsigned binary to decimal ASCII digit stream.
`default_nettype none
// Accepts one 64-bit unsigned number per input transfer and returns its decimal
// digits as ASCII characters, most significant first, without leading zeros
// (zero gives a single '0'); m_tlast marks the least significant digit. One
// number is handled at a time: a load, 64 double dabble shift steps, a skip
// for each leading zero (20 - digits of them), a check that finds the first
// digit, then the output of each digit, which stalls while the output side
// holds it back. The next number is taken once the last digit has been loaded
// into the output register.
module binary_to_decimal_ascii
	import bda_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [VALUE_W-1:0] s_tdata,  // [63:0] value
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,  // [5:0] digit_char, [7:6] zero
	output logic                    m_tlast   // last_digit
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	bda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bda_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.value    (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after a transfer");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] == 4'h3) && (m_tdata[3:0] <= 4'd9))
		else $error("output is not an ASCII digit");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $past(cmd.emit) && $past(sts.cnt_one))
		else $error("input ready before last digit was issued");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.skip, cmd.emit}))
		else $error("conflicting datapath commands");
`endif
endmodule
`default_nettype wire
